/* src/bra_pkg.sv */
`timescale 1ns / 1ps
package bra_pkg;
  localparam int CUSTOMER_COUNT = 5;
  localparam int RESOURCE_TYPES = 4;
  localparam int CUST_W = 3;
  localparam int AMT_W = 16;
  // signed working width: covers initial minus five allocations, or plus them
  localparam int WORK_W = 20;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_AVAIL = 3'd0;
  // maximum demand of customer c sits at this index plus c
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEMAND0 = 3'd1;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_BAD_CUST = 3'd1;
  localparam logic [2:0] ST_EXCEEDS = 3'd2;
  localparam logic [2:0] ST_UNSAFE = 3'd3;
  localparam logic [2:0] ST_REL_OVER = 3'd4;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [AMT_W-1:0] amt_t;
  typedef amt_t [RESOURCE_TYPES-1:0] amt_vec_t;
  typedef logic signed [WORK_W-1:0] work_t;
  typedef work_t [RESOURCE_TYPES-1:0] work_vec_t;

  // lane to merge: per-lane verdicts
  typedef struct packed {
    logic need_bad;   // request over need or over available
    logic rel_bad;    // release over allocation
    logic fits;       // need fits work vector
  } lane_flags_t;

  function automatic amt_t field16(input logic [CFG_W-1:0] r, input int t);
    return r[t*AMT_W +: AMT_W];
  endfunction
endpackage

/* src/bra_lane.sv */
`timescale 1ns / 1ps
// One resource type: checks an amount against need, available and allocation,
// and compares the selected customer's need with the work value.
module bra_lane (
  input  bra_pkg::amt_t  amount,
  input  bra_pkg::amt_t  alloc_cur,
  input  bra_pkg::amt_t  max_cur,
  input  bra_pkg::work_t avail,
  input  bra_pkg::work_t work,
  output bra_pkg::lane_flags_t flags
);
  bra_pkg::work_t need;
  bra_pkg::work_t amt_s;

  // need may go negative after a register change
  assign need = bra_pkg::work_t'({4'd0, max_cur}) - bra_pkg::work_t'({4'd0, alloc_cur});
  assign amt_s = bra_pkg::work_t'({4'd0, amount});

  assign flags.need_bad = (amt_s > need) || (amt_s > avail);
  assign flags.rel_bad = amount > alloc_cur;
  assign flags.fits = !(need > work);
endmodule

/* src/bankers_resource_allocator_core.sv */
`timescale 1ns / 1ps
// Banker's allocator core.
// Input: raise start with operation, customer and four amounts; a beat is
// taken at a rising edge where start is high and busy is low.
// Result: out_valid is high for exactly one cycle with out_status; the
// receiver cannot stall, so the result is simply dropped if not sampled.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// write only while idle. Index 0 is the initial amounts, 1..5 the maximum
// demand of customers 0..4; other indexes are ignored.
// Sequence after a beat is taken: a bad customer goes straight to the result.
// Otherwise available is summed over the customers first, one customer per
// cycle, then one check step follows; a release or a refused request answers
// next. A request that reaches the safety check visits one customer per cycle
// in passes over all customers, at most CUSTOMER_COUNT passes: a grant answers
// once every customer is done, an unsafe request after a roll-back step. busy
// stays high through the result beat, so a new item is taken only after the
// result.
// Four lanes, one per resource type, do the compares; a merge combines them.
// Reset clears the allocation table, the configuration registers and the
// sequencer; busy is low after reset.
module bankers_resource_allocator_core (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_operation,
  input  logic [2:0] in_customer,
  input  logic [15:0] in_amount_0,
  input  logic [15:0] in_amount_1,
  input  logic [15:0] in_amount_2,
  input  logic [15:0] in_amount_3,
  output logic out_valid,
  output logic [2:0] out_status,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [bra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bra_pkg::CFG_W-1:0] cfg_data
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUM   = 6'b000010,
    S_CHECK = 6'b000100,
    S_SAFE  = 6'b001000,
    S_UNDO  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  localparam int CC = bra_pkg::CUSTOMER_COUNT;
  localparam int RT = bra_pkg::RESOURCE_TYPES;

  state_t state_r, state_nxt;
  logic [bra_pkg::CFG_W-1:0] init_r;
  logic [bra_pkg::CFG_W-1:0] maxd_r [CC];
  bra_pkg::amt_vec_t alloc_r [CC];
  bra_pkg::amt_vec_t amt_r;
  logic op_r;
  logic [bra_pkg::CUST_W-1:0] cust_r, scan_r;
  bra_pkg::work_vec_t work_r;
  logic [CC-1:0] done_r;
  logic progress_r;
  logic [2:0] status_r;

  bra_pkg::amt_vec_t amt_in;
  bra_pkg::amt_vec_t alloc_sel, max_sel;
  bra_pkg::lane_flags_t [RT-1:0] flags;
  logic [bra_pkg::CUST_W-1:0] sel;
  logic any_need_bad, any_rel_bad, all_fit;

  assign amt_in = {in_amount_3, in_amount_2, in_amount_1, in_amount_0};
  assign busy = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = state_r == S_OUT;
  assign out_status = status_r;

  // lane customer: the scanned one in sum/safety, else the item's customer
  assign sel = (state_r == S_SUM || state_r == S_SAFE) ? scan_r : cust_r;
  always_comb begin
    alloc_sel = '0;
    max_sel = '0;
    for (int c = 0; c < CC; c++) begin
      if (sel == bra_pkg::CUST_W'(c)) begin
        alloc_sel = alloc_r[c];
        for (int t = 0; t < RT; t++) max_sel[t] = bra_pkg::field16(maxd_r[c], t);
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < RT; g++) begin : g_lane
      bra_lane u_lane (
        .amount(amt_r[g]), .alloc_cur(alloc_sel[g]), .max_cur(max_sel[g]),
        .avail(work_r[g]), .work(work_r[g]), .flags(flags[g])
      );
    end
  endgenerate

  // merge lane verdicts
  always_comb begin
    any_need_bad = 1'b0;
    any_rel_bad = 1'b0;
    all_fit = 1'b1;
    for (int t = 0; t < RT; t++) begin
      any_need_bad |= flags[t].need_bad;
      any_rel_bad |= flags[t].rel_bad;
      all_fit &= flags[t].fits;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = (in_customer >= bra_pkg::CUST_W'(CC)) ? S_OUT : S_SUM;
      S_SUM:   if (scan_r == bra_pkg::CUST_W'(CC - 1)) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (op_r == bra_pkg::OP_RELEASE || any_need_bad) ? S_OUT : S_SAFE;
      S_SAFE: begin
        if (&done_r) state_nxt = S_OUT;
        else if (scan_r == bra_pkg::CUST_W'(CC - 1) && !progress_r &&
                 (done_r[scan_r] || !all_fit)) state_nxt = S_UNDO;
      end
      S_UNDO:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r <= '0;
      for (int c = 0; c < CC; c++) begin
        maxd_r[c] <= '0;
        alloc_r[c] <= '0;
      end
      done_r <= '0;
      progress_r <= 1'b0;
      scan_r <= '0;
    end else begin
      state_r <= state_nxt;
      // configuration writes
      if (cfg_valid) begin
        if (cfg_index == bra_pkg::REG_INIT_AVAIL) init_r <= cfg_data;
        else if (cfg_index <= bra_pkg::CFG_IDX_W'(CC))
          maxd_r[cfg_index - bra_pkg::REG_MAX_DEMAND0] <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r <= in_operation;
            cust_r <= in_customer;
            amt_r <= amt_in;
            status_r <= bra_pkg::ST_BAD_CUST;
            scan_r <= '0;
            for (int t = 0; t < RT; t++)
              work_r[t] <= bra_pkg::work_t'({4'd0, bra_pkg::field16(init_r, t)});
          end
        end
        // subtract one customer's allocation per cycle
        S_SUM: begin
          for (int t = 0; t < RT; t++)
            work_r[t] <= work_r[t] - bra_pkg::work_t'({4'd0, alloc_sel[t]});
          scan_r <= (scan_r == bra_pkg::CUST_W'(CC - 1)) ? '0 : scan_r + 3'd1;
        end
        S_CHECK: begin
          done_r <= '0;
          progress_r <= 1'b0;
          if (op_r == bra_pkg::OP_RELEASE) begin
            if (any_rel_bad) status_r <= bra_pkg::ST_REL_OVER;
            else begin
              status_r <= bra_pkg::ST_DONE;
              for (int t = 0; t < RT; t++)
                alloc_r[cust_r][t] <= alloc_r[cust_r][t] - amt_r[t];
            end
          end else if (any_need_bad) begin
            status_r <= bra_pkg::ST_EXCEEDS;
          end else begin
            // tentative grant: allocation up, work down
            status_r <= bra_pkg::ST_DONE;
            for (int t = 0; t < RT; t++) begin
              alloc_r[cust_r][t] <= alloc_r[cust_r][t] + amt_r[t];
              work_r[t] <= work_r[t] - bra_pkg::work_t'({4'd0, amt_r[t]});
            end
          end
        end
        // one customer per cycle; passes repeat while progress is made
        S_SAFE: begin
          if (!done_r[scan_r] && all_fit) begin
            done_r[scan_r] <= 1'b1;
            for (int t = 0; t < RT; t++)
              work_r[t] <= work_r[t] + bra_pkg::work_t'({4'd0, alloc_sel[t]});
          end
          if (scan_r == bra_pkg::CUST_W'(CC - 1)) begin
            scan_r <= '0;
            progress_r <= 1'b0;
          end else begin
            scan_r <= scan_r + 3'd1;
            if (!done_r[scan_r] && all_fit) progress_r <= 1'b1;
          end
        end
        // roll back the tentative grant
        S_UNDO: begin
          status_r <= bra_pkg::ST_UNSAFE;
          for (int t = 0; t < RT; t++)
            alloc_r[cust_r][t] <= alloc_r[cust_r][t] - amt_r[t];
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat longer than one cycle");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= bra_pkg::ST_REL_OVER) else $error("bad status");
  a_undo_unsafe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UNDO |=> out_status == bra_pkg::ST_UNSAFE) else $error("undo status");
`endif
endmodule
